>>> sv/wpse_pkg.sv
// wpse_pkg: shared types, constants and register indexes for the pixel slot encoder
// no dependencies; imported by every module of the block
package wpse_pkg;

  // code run per slot and colour word layout
  localparam int SLOT_CODES = 24;
  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 3 * BYTE_W;
  localparam int CNT_W      = $clog2(SLOT_CODES);
  localparam int STEP_W     = $clog2(BYTE_W);
  localparam int CFG_W      = 16;
  localparam int CODE_W     = 16;
  localparam int SLOT_W     = 16;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // top bit of a colour byte, feeds the divider one bit a step
  localparam logic [BYTE_W-1:0] BIT_TOP = 8'b1000_0000;

  // register reset values
  localparam logic [SLOT_W-1:0] PIXEL_COUNT_RST  = 16'd256;
  localparam logic [SLOT_W-1:0] FRAME_PERIOD_RST = 16'd512;
  localparam logic [BYTE_W-1:0] CONTRAST_RST     = 8'd65;
  localparam logic [BYTE_W-1:0] BRIGHTNESS_RST   = 8'd9;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_PIXEL_COUNT  = 3'd0,
    CFG_FRAME_PERIOD = 3'd1,
    CFG_CONTRAST     = 3'd2,
    CFG_BRIGHTNESS   = 3'd3,
    CFG_ONE_CODE     = 3'd4,
    CFG_ZERO_CODE    = 3'd5
  } wpse_cfg_idx_t;

  // front state machine
  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_CLASS = 4'b0010,
    F_DIV   = 4'b0100,
    F_PUSH  = 4'b1000
  } wpse_fstate_t;

  // one queued slot: gap flag and scaled grb word
  typedef struct packed {
    logic              gap;
    logic [WORD_W-1:0] bits;
  } wpse_entry_t;

endpackage

>>> sv/wpse_front.sv
// wpse_front: takes pixel slot beats, steps the slot counter, classifies the slot,
// divides and scales the colour bytes and queues each slot that gives codes; uses wpse_pkg
module wpse_front import wpse_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_red,
  input  logic [BYTE_W-1:0] in_green,
  input  logic [BYTE_W-1:0] in_blue,
  input  logic [SLOT_W-1:0] pixel_count,
  input  logic [SLOT_W-1:0] frame_period,
  input  logic [BYTE_W-1:0] contrast,
  input  logic [BYTE_W-1:0] brightness,
  output logic              push_valid,
  output wpse_entry_t       push_entry,
  input  logic              push_ready
);

  wpse_fstate_t      state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SLOT_W-1:0] slot_inc;
  logic              gap_r, gap_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [BYTE_W-1:0] dvd_r [3];
  logic [BYTE_W-1:0] dvd_nxt [3];
  logic [BYTE_W-1:0] rem_r [3];
  logic [BYTE_W-1:0] rem_nxt [3];
  logic [BYTE_W:0]   trial [3];
  logic [BYTE_W-1:0] scaled [3];
  logic [2*BYTE_W-1:0] prod [3];
  logic [SLOT_W:0]   pc_plus1;
  logic              is_gap, is_pix, accept;

  assign accept   = in_valid && (state_r == F_IDLE);
  assign in_stall = (state_r != F_IDLE);
  assign slot_inc = slot_r + SLOT_W'(1);
  assign pc_plus1 = {1'b0, pixel_count} + (SLOT_W+1)'(1);
  assign is_gap   = (slot_r == pixel_count) || ({1'b0, slot_r} == pc_plus1);
  assign is_pix   = (slot_r < pixel_count);

  // restoring divide step and scale multiply, one lane per colour
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trial[i]  = {rem_r[i], |(dvd_r[i] & BIT_TOP)};
      prod[i]   = (2*BYTE_W)'(dvd_r[i]) * (2*BYTE_W)'(brightness);
      scaled[i] = prod[i][BYTE_W-1:0];
    end
  end

  assign push_valid      = (state_r == F_PUSH);
  assign push_entry.gap  = gap_r;
  assign push_entry.bits = {scaled[1], scaled[0], scaled[2]};

  // slot sequencing
  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    gap_nxt   = gap_r;
    step_nxt  = step_r;
    for (int i = 0; i < 3; i++) begin
      dvd_nxt[i] = dvd_r[i];
      rem_nxt[i] = rem_r[i];
    end
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          slot_nxt   = (slot_inc == frame_period) ? '0 : slot_inc;
          dvd_nxt[0] = in_red;
          dvd_nxt[1] = in_green;
          dvd_nxt[2] = in_blue;
          state_nxt  = F_CLASS;
        end
      end
      F_CLASS: begin
        step_nxt = '0;
        for (int i = 0; i < 3; i++) rem_nxt[i] = '0;
        if (is_gap) begin
          gap_nxt   = 1'b1;
          state_nxt = F_PUSH;
        end else if (is_pix) begin
          gap_nxt   = 1'b0;
          // a zero divisor leaves the bytes as they are
          state_nxt = (contrast == '0) ? F_PUSH : F_DIV;
        end else begin
          state_nxt = F_IDLE;
        end
      end
      F_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (trial[i] >= {1'b0, contrast}) begin
            rem_nxt[i] = BYTE_W'(trial[i] - {1'b0, contrast});
            dvd_nxt[i] = {dvd_r[i][BYTE_W-2:0], 1'b1};
          end else begin
            rem_nxt[i] = trial[i][BYTE_W-1:0];
            dvd_nxt[i] = {dvd_r[i][BYTE_W-2:0], 1'b0};
          end
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(BYTE_W-1)) state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (push_ready) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    gap_r  <= gap_nxt;
    step_r <= step_nxt;
    for (int i = 0; i < 3; i++) begin
      dvd_r[i] <= dvd_nxt[i];
      rem_r[i] <= rem_nxt[i];
    end
  end

endmodule

>>> sv/wpse_queue.sv
// wpse_queue: short first-in first-out queue of slot entries between front and back
// uses wpse_pkg for the entry type
module wpse_queue import wpse_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  input  wpse_entry_t push_entry,
  output logic        push_ready,
  output logic        pop_valid,
  output wpse_entry_t pop_entry,
  input  logic        pop_ready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  wpse_entry_t   mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != NW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + AW'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + AW'(1);
    if (do_push && !do_pop)      count_nxt = count_r + NW'(1);
    else if (do_pop && !do_push) count_nxt = count_r - NW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_entry;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(DEPTH)) else $error("queue fill count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |=> (count_r == '0) || $past(do_push))
    else $error("queue filled without a push");
  a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == NW'(DEPTH)) |-> !do_push)
    else $error("push into a full queue");
`endif

endmodule

>>> sv/wpse_back.sv
// wpse_back: turns one queued slot into a run of duty code beats, msb first,
// through a registered output stage; uses wpse_pkg
module wpse_back import wpse_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  input  wpse_entry_t       pop_entry,
  output logic              pop_ready,
  input  logic [CODE_W-1:0] one_code,
  input  logic [CODE_W-1:0] zero_code,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] out_duty,
  output logic              out_is_gap,
  output logic              out_pixel_taken,
  output logic              out_last
);

  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SLOT_CODES - 1);

  logic              active_r, active_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic              gap_r, gap_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [CODE_W-1:0] duty_r, duty_nxt;
  logic              ogap_r, ogap_nxt;
  logic              taken_r, taken_nxt;
  logic              olast_r, olast_nxt;
  logic              load, emit, run_end;

  assign load      = !ovalid_r || !out_stall;
  assign emit      = active_r && load;
  assign run_end   = emit && (cnt_r == LAST_CNT);
  assign pop_ready = !active_r || run_end;

  // serializer and output stage
  always_comb begin
    active_nxt = active_r;
    word_nxt   = word_r;
    gap_nxt    = gap_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r;
    duty_nxt   = duty_r;
    ogap_nxt   = ogap_r;
    taken_nxt  = taken_r;
    olast_nxt  = olast_r;
    if (emit) begin
      ovalid_nxt = 1'b1;
      duty_nxt   = gap_r ? '0 : (word_r[WORD_W-1] ? one_code : zero_code);
      ogap_nxt   = gap_r;
      taken_nxt  = !gap_r;
      olast_nxt  = run_end;
      word_nxt   = {word_r[WORD_W-2:0], 1'b0};
      cnt_nxt    = cnt_r + CNT_W'(1);
      if (run_end) active_nxt = 1'b0;
    end else if (load) begin
      ovalid_nxt = 1'b0;
    end
    // next slot enters when no run is active or as the current run ends
    if (pop_valid && pop_ready) begin
      active_nxt = 1'b1;
      word_nxt   = pop_entry.bits;
      gap_nxt    = pop_entry.gap;
      cnt_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ovalid_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      ovalid_r <= ovalid_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r  <= word_nxt;
    gap_r   <= gap_nxt;
    duty_r  <= duty_nxt;
    ogap_r  <= ogap_nxt;
    taken_r <= taken_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid       = ovalid_r;
  assign out_duty        = duty_r;
  assign out_is_gap      = ogap_r;
  assign out_pixel_taken = taken_r;
  assign out_last        = olast_r;

endmodule

>>> sv/ws2812_pixel_slot_encoder_unit.sv
// ws2812_pixel_slot_encoder_unit: top level, configuration registers, front, queue, back
// depends on wpse_pkg, wpse_front, wpse_queue, wpse_back
//
//   port group  direction  handshake            payload
//   in_*        in         in_valid / in_stall  in_red, in_green, in_blue
//   out_*       out        out_valid/out_stall  out_duty, out_is_gap, out_pixel_taken, out_last
//   cfg_*       in         cfg_we               cfg_addr, cfg_wdata
//
// a pixel or gap slot gives 24 beats, one per cycle while out_stall is low, set by the back serializer;
// the front handles a pixel slot in steps (accept, classify, 8 divide steps, push),
// only accept, classify and push when contrast is zero or for a gap slot, accept and
// classify for a slot that gives nothing; its push waits for queue space, overlapped with the back run.
// the front can take the next slot while the back still serializes earlier ones.
// rst_n is synchronous; it clears the slot counter, queue and output stage and
// loads the register defaults. out_stall holds the output beat and backs up the queue.
module ws2812_pixel_slot_encoder_unit import wpse_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_red,
  input  logic [BYTE_W-1:0] in_green,
  input  logic [BYTE_W-1:0] in_blue,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] out_duty,
  output logic              out_is_gap,
  output logic              out_pixel_taken,
  output logic              out_last,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  logic [SLOT_W-1:0] pixel_count_r;
  logic [SLOT_W-1:0] frame_period_r;
  logic [BYTE_W-1:0] contrast_r;
  logic [BYTE_W-1:0] brightness_r;
  logic [CODE_W-1:0] one_code_r;
  logic [CODE_W-1:0] zero_code_r;

  logic        push_valid, push_ready, pop_valid, pop_ready;
  wpse_entry_t push_entry, pop_entry;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_count_r  <= PIXEL_COUNT_RST;
      frame_period_r <= FRAME_PERIOD_RST;
      contrast_r     <= CONTRAST_RST;
      brightness_r   <= BRIGHTNESS_RST;
      one_code_r     <= '0;
      zero_code_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PIXEL_COUNT:  pixel_count_r  <= cfg_wdata;
        CFG_FRAME_PERIOD: frame_period_r <= cfg_wdata;
        CFG_CONTRAST:     contrast_r     <= cfg_wdata[BYTE_W-1:0];
        CFG_BRIGHTNESS:   brightness_r   <= cfg_wdata[BYTE_W-1:0];
        CFG_ONE_CODE:     one_code_r     <= cfg_wdata;
        CFG_ZERO_CODE:    zero_code_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  wpse_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .pixel_count  (pixel_count_r),
    .frame_period (frame_period_r),
    .contrast     (contrast_r),
    .brightness   (brightness_r),
    .push_valid   (push_valid),
    .push_entry   (push_entry),
    .push_ready   (push_ready)
  );

  wpse_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_ready  (pop_ready)
  );

  wpse_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_entry       (pop_entry),
    .pop_ready       (pop_ready),
    .one_code        (one_code_r),
    .zero_code       (zero_code_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_duty        (out_duty),
    .out_is_gap      (out_is_gap),
    .out_pixel_taken (out_pixel_taken),
    .out_last        (out_last)
  );

`ifndef ASSERT_OFF
  a_gap_duty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_gap) |-> (out_duty == '0))
    else $error("gap beat with nonzero duty");
  a_gap_xor_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_gap != out_pixel_taken))
    else $error("beat neither gap nor pixel");
  a_run_kind_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=> !out_valid || $stable(out_is_gap))
    else $error("slot kind changed inside a run");
`endif

endmodule

>>> sim/pixel_code_checker.sv
// pixel_code_checker: predicts the duty code beats of each pixel or gap slot and checks the result channel
// depends on wpse_pkg; instantiated by tb_top beside the encoder
`timescale 1ns / 100ps

module pixel_code_checker import wpse_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [BYTE_W-1:0] in_red,
  input  logic [BYTE_W-1:0] in_green,
  input  logic [BYTE_W-1:0] in_blue,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [CODE_W-1:0] out_duty,
  input  logic              out_is_gap,
  input  logic              out_pixel_taken,
  input  logic              out_last,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output int                fail_count,
  output int                pending_beats,
  output logic [SLOT_W-1:0] slot_now
);

  // one expected result beat
  typedef struct packed {
    logic [CODE_W-1:0] duty;
    logic              gap;
    logic              taken;
    logic              last;
  } code_beat_t;

  code_beat_t        expected_codes[$];
  code_beat_t        want_beat;
  logic [SLOT_W-1:0] slot_cnt;
  logic [SLOT_W-1:0] reg_pixel_count;
  logic [SLOT_W-1:0] reg_frame_period;
  logic [BYTE_W-1:0] reg_contrast;
  logic [BYTE_W-1:0] reg_brightness;
  logic [CODE_W-1:0] reg_one_code;
  logic [CODE_W-1:0] reg_zero_code;

  // divide by contrast (skipped when zero), multiply by brightness, keep low byte
  function automatic logic [BYTE_W-1:0] scale_color(input logic [BYTE_W-1:0] level);
    logic [BYTE_W-1:0]   quot;
    logic [2*BYTE_W-1:0] prod;
    quot = (reg_contrast != '0) ? level / reg_contrast : level;
    prod = quot * reg_brightness;
    return prod[BYTE_W-1:0];
  endfunction

  // advance the slot counter and queue the beats this slot produces
  task automatic predict_slot_codes(input logic [BYTE_W-1:0] red, green, blue);
    logic [SLOT_W:0]   slot_ext;
    logic [WORD_W-1:0] grb;
    code_beat_t        beat;
    int                k;
    slot_cnt = slot_cnt + 1'b1;
    if (slot_cnt == reg_frame_period) begin
      slot_cnt = '0;
    end
    slot_ext = {1'b0, slot_cnt};
    // reset gap wins over the pixel compare; pixel_count + 1 kept in 17 bits
    if (slot_ext == {1'b0, reg_pixel_count} || slot_ext == {1'b0, reg_pixel_count} + 1'b1) begin
      for (k = 0; k < SLOT_CODES; k++) begin
        beat.duty  = '0;
        beat.gap   = 1'b1;
        beat.taken = 1'b0;
        beat.last  = (k == SLOT_CODES - 1);
        expected_codes.push_back(beat);
      end
    end else if (slot_cnt < reg_pixel_count) begin
      grb = {scale_color(green), scale_color(red), scale_color(blue)};
      for (k = 0; k < SLOT_CODES; k++) begin
        beat.duty  = grb[WORD_W-1-k] ? reg_one_code : reg_zero_code;
        beat.gap   = 1'b0;
        beat.taken = 1'b1;
        beat.last  = (k == SLOT_CODES - 1);
        expected_codes.push_back(beat);
      end
    end
  endtask

  task automatic check_field(input string field, input logic [CODE_W-1:0] want,
                             input logic [CODE_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reg_pixel_count  = PIXEL_COUNT_RST;
      reg_frame_period = FRAME_PERIOD_RST;
      reg_contrast     = CONTRAST_RST;
      reg_brightness   = BRIGHTNESS_RST;
      reg_one_code     = '0;
      reg_zero_code    = '0;
      slot_cnt         = '0;
      fail_count       = 0;
      expected_codes.delete();
    end else begin
      // result beat against the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_codes.size() == 0) begin
          fail_count++;
          $display("%0t ns: unexpected beat, expected none, got duty %0h gap %b taken %b last %b",
                   $time, out_duty, out_is_gap, out_pixel_taken, out_last);
        end else begin
          want_beat = expected_codes.pop_front();
          check_field("duty", want_beat.duty, out_duty);
          check_field("is_gap", want_beat.gap, out_is_gap);
          check_field("pixel_taken", want_beat.taken, out_pixel_taken);
          check_field("last", want_beat.last, out_last);
        end
      end
      // accepted pixel request
      if (in_valid && !in_stall) begin
        predict_slot_codes(in_red, in_green, in_blue);
      end
      // register shadow
      if (cfg_we) begin
        case (wpse_cfg_idx_t'(cfg_addr))
          CFG_PIXEL_COUNT:  reg_pixel_count  = cfg_wdata;
          CFG_FRAME_PERIOD: reg_frame_period = cfg_wdata;
          CFG_CONTRAST:     reg_contrast     = cfg_wdata[BYTE_W-1:0];
          CFG_BRIGHTNESS:   reg_brightness   = cfg_wdata[BYTE_W-1:0];
          CFG_ONE_CODE:     reg_one_code     = cfg_wdata;
          CFG_ZERO_CODE:    reg_zero_code    = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending_beats <= expected_codes.size();
    slot_now      <= slot_cnt;
  end

endmodule

>>> sim/tb_top.sv
// tb_top: stimulus, stall patterns and verdict for ws2812_pixel_slot_encoder_unit
// depends on wpse_pkg, ws2812_pixel_slot_encoder_unit and pixel_code_checker
`timescale 1ns / 100ps

module tb_top import wpse_pkg::*; ;

  localparam int          SETTLE_CYCLES = 16;
  localparam int          HOLD_CYCLES   = 400;
  localparam int unsigned LIMIT_CYCLES  = 1_500_000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SPARSE,
    STALL_EVERY_THIRD,
    STALL_HEAVY
  } stall_mode_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic [BYTE_W-1:0] in_red    = '0;
  logic [BYTE_W-1:0] in_green  = '0;
  logic [BYTE_W-1:0] in_blue   = '0;
  logic              out_stall = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [2:0]        cfg_addr  = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_stall;
  logic              out_valid;
  logic [CODE_W-1:0] out_duty;
  logic              out_is_gap;
  logic              out_pixel_taken;
  logic              out_last;

  int                fail_count;
  int                pending_beats;
  logic [SLOT_W-1:0] slot_now;
  int unsigned       cycle_cnt  = 0;
  int                hold_ask   = 0;
  int                hold_taken = 0;
  int                hold_left  = 0;
  int                pat_left   = 0;
  int                pat_tick   = 0;
  stall_mode_t       stall_mode = STALL_NONE;
  logic [23:0]       directed_pix[$];

  ws2812_pixel_slot_encoder_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_duty        (out_duty),
    .out_is_gap      (out_is_gap),
    .out_pixel_taken (out_pixel_taken),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata)
  );

  pixel_code_checker code_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_duty        (out_duty),
    .out_is_gap      (out_is_gap),
    .out_pixel_taken (out_pixel_taken),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_beats   (pending_beats),
    .slot_now        (slot_now)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= LIMIT_CYCLES);
    $display("TB_ERROR");
    $finish;
  end

  // receiver: long hold-off on request, else a stall pattern that changes now and then
  always @(posedge clk) begin
    pat_tick <= pat_tick + 1;
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_ask != hold_taken) begin
      out_stall  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      hold_taken <= hold_ask;
    end else begin
      if (pat_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        pat_left   <= $urandom_range(16, 96);
      end else begin
        pat_left <= pat_left - 1;
      end
      case (stall_mode)
        STALL_NONE:        out_stall <= 1'b0;
        STALL_SPARSE:      out_stall <= ($urandom_range(0, 3) == 0);
        STALL_EVERY_THIRD: out_stall <= (pat_tick % 3 == 0);
        default:           out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic write_reg(input wpse_cfg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // all six registers, only while the encoder is idle
  task automatic set_config(input logic [15:0] pix_cnt, period, input logic [7:0] contr, bright,
                            input logic [15:0] one_val, zero_val);
    write_reg(CFG_PIXEL_COUNT, pix_cnt);
    write_reg(CFG_FRAME_PERIOD, period);
    write_reg(CFG_CONTRAST, {8'd0, contr});
    write_reg(CFG_BRIGHTNESS, {8'd0, bright});
    write_reg(CFG_ONE_CODE, one_val);
    write_reg(CFG_ZERO_CODE, zero_val);
    cfg_we <= 1'b0;
  endtask

  // send n pixel beats in random bursts, or back to back when steady
  task automatic send_run(input int n, input bit steady, input bit from_list);
    int          i;
    int          burst;
    logic [23:0] pix;
    burst = $urandom_range(1, 8);
    for (i = 0; i < n; i++) begin
      pix = from_list ? directed_pix.pop_front() : 24'($urandom);
      in_valid <= 1'b1;
      in_red   <= pix[23:16];
      in_green <= pix[15:8];
      in_blue  <= pix[7:0];
      @(posedge clk);
      while (in_stall) @(posedge clk);
      burst--;
      if (!steady && burst == 0 && i != n - 1) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst = $urandom_range(1, 8);
      end
    end
    in_valid <= 1'b0;
  endtask

  // wait for every expected beat, then let the front finish slots that give nothing
  task automatic drain();
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int          p;
    logic [15:0] pix_cnt;
    logic [15:0] period;
    logic [7:0]  contr;
    logic [7:0]  bright;
    directed_pix = '{
      24'hFFFFFF, 24'h804100,
      24'h000000, 24'hFFFFFF, 24'h123456, 24'h654321,
      24'h800180, 24'hAA55F0, 24'h01FE7F, 24'h0F0F0F,
      24'hFFFFFF, 24'h01FF80, 24'hFE0381, 24'h7F40C0,
      24'hFFFFFF, 24'h80FE7F, 24'h00FF01, 24'hFFFFFF,
      24'hFFFFFF, 24'h000000, 24'hA5A5A5
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults straight after reset
    send_run(2, 1'b0, 1'b1);
    drain();
    // unity scaling, gaps at 5 and 6, wrap at 7
    set_config(16'd5, 16'd7, 8'd1, 8'd1, 16'hFFFF, 16'h0000);
    send_run(8, 1'b0, 1'b1);
    drain();
    // contrast zero skips the divide, brightness max truncates
    set_config(16'd3, 16'd5, 8'd0, 8'd255, 16'h0000, 16'hFFFF);
    send_run(4, 1'b0, 1'b1);
    drain();
    // pixel count at max: slot 0 stays a pixel slot
    set_config(16'd65535, 16'd3, 8'd255, 8'd255, 16'h1234, 16'hFEDC);
    send_run(4, 1'b0, 1'b1);
    drain();
    // pixel count zero with period one: every slot is slot 0, a gap
    set_config(16'd0, 16'd1, 8'd7, 8'd3, 16'h5A5A, 16'hA5A5);
    send_run(3, 1'b0, 1'b1);
    drain();
    // period zero: the counter never matches it and climbs past the gap slots
    set_config(16'd3, 16'd0, 8'd3, 8'd5, 16'($urandom), 16'($urandom));
    send_run(16, 1'b1, 1'b0);
    drain();

    // random settings
    for (p = 0; p < 8; p++) begin
      if (p == 2) begin
        // receiver holds off while the sender keeps pushing
        set_config(16'd65535, 16'd65535, 8'd1, 8'd255, 16'hFFFF, 16'h0000);
        hold_ask <= hold_ask + 1;
      end else begin
        case ($urandom_range(0, 2))
          0:       pix_cnt = 16'($urandom_range(0, 4));
          1:       pix_cnt = 16'($urandom_range(5, 30));
          default: pix_cnt = 16'd65535;
        endcase
        period = slot_now + 16'd1 + 16'($urandom_range(0, 30));
        case ($urandom_range(0, 4))
          0:       contr = 8'd0;
          1:       contr = 8'd1;
          2:       contr = 8'd255;
          default: contr = 8'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 3))
          0:       bright = 8'd0;
          1:       bright = 8'd255;
          default: bright = 8'($urandom);
        endcase
        set_config(pix_cnt, period, contr, bright, 16'($urandom), 16'($urandom));
      end
      send_run(20, p == 2, 1'b0);
      drain();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
